/* rtl/ef3_pkg.sv */
// ----------------------------------------------------------------------------
// ef3_pkg
// Shared types and constants of the 3x3 emboss filter.
// ----------------------------------------------------------------------------
package ef3_pkg;

  localparam int PIX_W    = 8;
  localparam int CFG_W    = 13;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int OROW_W   = 12;

  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 13'd4096;

  // register indexes of the configuration port
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // control of the window stage, registered from the acceptance decision
  typedef struct packed {
    logic pix;       // shift window, write line stores
    logic emit;      // produce one result
    logic interior;  // result is not on the frame border
    logic last;      // final result of the frame
  } ef3_stage_t;

endpackage

/* rtl/emboss_filter_3x3_unit.sv */
// ----------------------------------------------------------------------------
// emboss_filter_3x3_unit
// Streaming 3x3 emboss filter on 8-bit raster pixels with two line stores,
// saturation to 0..255, zero border and frame-last marking.
//
//   channel   signals                          direction
//   ------    -------------------------------  ---------
//   config    cfg_write, cfg_index, cfg_data   in, write only, no wait
//   input     in_valid/in_ready, op, pixel_in  in
//   output    out_valid/out_ready, pixel_out,  out
//             frame_last
//
// One item per clock sustained while the result queue has space. A result is
// offered from the queue: the line store read and the stage control are registered
// at the input transfer, then the window shifts and the queue takes the result.
// Consecutive pixels on the same column are served by forwarding the
// store write in flight. Reset is synchronous and needs no clearing pass.
// A stalled output fills a three-entry queue, then drops in_ready.
// ----------------------------------------------------------------------------
module emboss_filter_3x3_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [ef3_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [ef3_pkg::PIX_W-1:0]     pixel_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ef3_pkg::PIX_W-1:0]     pixel_out,
  output logic                          frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                       accept;
  logic                       rd_en;
  logic [CW-1:0]              rd_addr;
  ef3_pkg::ef3_stage_t        s1;
  logic [CW-1:0]              s1_col;
  logic [ef3_pkg::PIX_W-1:0]  s1_px;
  logic [ef3_pkg::PIX_W-1:0]  up_rd_data, mid_rd_data;
  logic                       wr_en;
  logic [CW-1:0]              wr_addr;
  logic [ef3_pkg::PIX_W-1:0]  up_wr_data, mid_wr_data;
  logic                       push, push_last;
  logic [ef3_pkg::PIX_W-1:0]  push_pixel;

  assign accept = in_valid && in_ready;

  ef3_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .op        (op),
    .pixel_in  (pixel_in),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .s1        (s1),
    .s1_col    (s1_col),
    .s1_px     (s1_px)
  );

  ef3_line_mem #(.DEPTH(MAX_WIDTH)) u_upper (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (up_rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (up_wr_data)
  );

  ef3_line_mem #(.DEPTH(MAX_WIDTH)) u_middle (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (mid_rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (mid_wr_data)
  );

  ef3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk         (clk),
    .rst         (rst),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .s1          (s1),
    .s1_col      (s1_col),
    .s1_px       (s1_px),
    .up_rd_data  (up_rd_data),
    .mid_rd_data (mid_rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .up_wr_data  (up_wr_data),
    .mid_wr_data (mid_wr_data),
    .push        (push),
    .push_pixel  (push_pixel),
    .push_last   (push_last)
  );

  ef3_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .pending    (s1.emit),
    .push       (push),
    .push_pixel (push_pixel),
    .push_last  (push_last),
    .space      (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

endmodule

/* rtl/ef3_line_mem.sv */
// ----------------------------------------------------------------------------
// ef3_line_mem
// One line store: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ef3_line_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rd_en,
  input  logic [$clog2(DEPTH)-1:0]           rd_addr,
  output logic [ef3_pkg::PIX_W-1:0]          rd_data,
  input  logic                               wr_en,
  input  logic [$clog2(DEPTH)-1:0]           wr_addr,
  input  logic [ef3_pkg::PIX_W-1:0]          wr_data
);

  logic [ef3_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/ef3_ctrl.sv */
// ----------------------------------------------------------------------------
// ef3_ctrl
// Configuration registers, input and output raster counters, emit decision
// and line store read issue.
// ----------------------------------------------------------------------------
module ef3_ctrl #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_index,
  input  logic [ef3_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              accept,
  input  logic                              op,
  input  logic [ef3_pkg::PIX_W-1:0]         pixel_in,
  output logic                              rd_en,
  output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
  output ef3_pkg::ef3_stage_t               s1,
  output logic [$clog2(MAX_WIDTH)-1:0]      s1_col,
  output logic [ef3_pkg::PIX_W-1:0]         s1_px
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WB = $clog2(MAX_WIDTH + 1);
  localparam int DB = $clog2(MAX_WIDTH + 3);
  localparam int HW = ef3_pkg::HEIGHT_W;

  logic [ef3_pkg::WIDTH_W-1:0]  image_width;
  logic [HW-1:0]                image_height;
  logic [CW-1:0]                in_col, in_col_next;
  logic [HW-1:0]                in_row, in_row_next;
  logic [DB-1:0]                lag, lag_next;
  logic [CW-1:0]                out_col, out_col_next;
  logic [ef3_pkg::OROW_W-1:0]   out_row, out_row_next;

  logic [WB-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic          complete, is_pixel, col_last, emit;
  logic          out_last_col, interior, frame_end;
  ef3_pkg::ef3_stage_t stage;

  always_comb begin
    if (image_width == '0) begin
      eff_w = WB'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      eff_w = WB'(MAX_WIDTH);
    end else begin
      eff_w = WB'(image_width);
    end
    if (image_height == '0) begin
      eff_h = HW'(1);
    end else if (image_height > ef3_pkg::MAX_HEIGHT) begin
      eff_h = ef3_pkg::MAX_HEIGHT;
    end else begin
      eff_h = image_height;
    end
  end

  always_comb begin
    complete     = in_row >= eff_h;
    is_pixel     = (op == ef3_pkg::OP_PIXEL) && !complete;
    col_last     = (WB'(in_col) + WB'(1)) == eff_w;
    // lag counts pixels received but not yet output
    emit         = is_pixel ? (lag >= DB'(eff_w) + DB'(1)) : complete;
    out_last_col = (WB'(out_col) + WB'(1)) == eff_w;
    frame_end    = out_last_col && ((HW'(out_row) + HW'(1)) == eff_h);
    interior     = (out_row != '0) && ((HW'(out_row) + HW'(1)) < eff_h) &&
                   (out_col != '0) && ((WB'(out_col) + WB'(1)) < eff_w);
  end

  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    lag_next     = lag;
    out_col_next = out_col;
    out_row_next = out_row;
    if (cfg_write) begin
      in_col_next  = '0;
      in_row_next  = '0;
      lag_next     = '0;
      out_col_next = '0;
      out_row_next = '0;
    end else if (accept) begin
      if (is_pixel) begin
        if (col_last) begin
          in_col_next = '0;
          in_row_next = in_row + HW'(1);
        end else begin
          in_col_next = in_col + CW'(1);
        end
        if (!emit) begin
          lag_next = lag + DB'(1);
        end
      end else if (emit) begin
        lag_next = lag - DB'(1);
      end
      if (emit) begin
        if (frame_end) begin
          in_col_next  = '0;
          in_row_next  = '0;
          lag_next     = '0;
          out_col_next = '0;
          out_row_next = '0;
        end else if (out_last_col) begin
          out_col_next = '0;
          out_row_next = out_row + ef3_pkg::OROW_W'(1);
        end else begin
          out_col_next = out_col + CW'(1);
        end
      end
    end
  end

  always_comb begin
    stage.pix      = accept && is_pixel;
    stage.emit     = accept && emit;
    stage.interior = interior;
    stage.last     = frame_end;
  end

  assign rd_en   = accept && is_pixel;
  assign rd_addr = in_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= ef3_pkg::WIDTH_W'(256);
      image_height <= HW'(256);
      in_col       <= '0;
      in_row       <= '0;
      lag          <= '0;
      out_col      <= '0;
      out_row      <= '0;
      s1           <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          ef3_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[ef3_pkg::WIDTH_W-1:0];
          ef3_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        endcase
      end
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      lag     <= lag_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      s1      <= stage;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col <= in_col;
      s1_px  <= pixel_in;
    end
  end

endmodule

/* rtl/ef3_window.sv */
// ----------------------------------------------------------------------------
// ef3_window
// Window stage: merges line store read data (with forwarding of the write
// in flight), shifts the 3x3 window, writes the stores back and computes
// the saturated emboss sum.
// ----------------------------------------------------------------------------
module ef3_window #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
  input  ef3_pkg::ef3_stage_t               s1,
  input  logic [$clog2(MAX_WIDTH)-1:0]      s1_col,
  input  logic [ef3_pkg::PIX_W-1:0]         s1_px,
  input  logic [ef3_pkg::PIX_W-1:0]         up_rd_data,
  input  logic [ef3_pkg::PIX_W-1:0]         mid_rd_data,
  output logic                              wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0]      wr_addr,
  output logic [ef3_pkg::PIX_W-1:0]         up_wr_data,
  output logic [ef3_pkg::PIX_W-1:0]         mid_wr_data,
  output logic                              push,
  output logic [ef3_pkg::PIX_W-1:0]         push_pixel,
  output logic                              push_last
);

  logic [8:0][ef3_pkg::PIX_W-1:0] win, win_next;
  logic                           fwd;
  logic [ef3_pkg::PIX_W-1:0]      fwd_up, fwd_mid;
  logic [ef3_pkg::PIX_W-1:0]      up_eff, mid_eff;

  function automatic logic [ef3_pkg::PIX_W-1:0] emboss(
    input logic [8:0][ef3_pkg::PIX_W-1:0] w
  );
    logic [10:0] pos;
    logic [10:0] neg;
    logic [10:0] diff;
    pos  = 11'(w[4]) + 11'(w[5]) + 11'(w[7]) + {2'b0, w[8], 1'b0};
    neg  = {2'b0, w[0], 1'b0} + 11'(w[1]) + 11'(w[3]);
    diff = pos - neg;
    if (neg >= pos) begin
      return '0;
    end else if (diff > 11'd255) begin
      return 8'd255;
    end else begin
      return diff[7:0];
    end
  endfunction

  // a read issued while the previous pixel writes the same column takes
  // the data being written
  assign up_eff  = fwd ? fwd_up  : up_rd_data;
  assign mid_eff = fwd ? fwd_mid : mid_rd_data;

  always_comb begin
    win_next = win;
    if (s1.pix) begin
      win_next[0] = win[1];
      win_next[1] = win[2];
      win_next[2] = up_eff;
      win_next[3] = win[4];
      win_next[4] = win[5];
      win_next[5] = mid_eff;
      win_next[6] = win[7];
      win_next[7] = win[8];
      win_next[8] = s1_px;
    end
  end

  assign wr_en       = s1.pix;
  assign wr_addr     = s1_col;
  assign up_wr_data  = mid_eff;
  assign mid_wr_data = s1_px;

  assign push       = s1.emit;
  assign push_pixel = s1.interior ? emboss(win_next) : '0;
  assign push_last  = s1.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      fwd <= 1'b0;
    end else begin
      win <= win_next;
      if (rd_en) begin
        fwd <= s1.pix && (s1_col == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_up  <= mid_eff;
      fwd_mid <= s1_px;
    end
  end

endmodule

/* rtl/ef3_out_fifo.sv */
// ----------------------------------------------------------------------------
// ef3_out_fifo
// Three-entry result queue; decouples the output handshake from the
// pipeline and grants input ready from registered state only.
// ----------------------------------------------------------------------------
module ef3_out_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pending,
  input  logic                          push,
  input  logic [ef3_pkg::PIX_W-1:0]     push_pixel,
  input  logic                          push_last,
  output logic                          space,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ef3_pkg::PIX_W-1:0]     pixel_out,
  output logic                          frame_last
);

  localparam logic [2:0] DEPTH = 3'd3;

  logic [ef3_pkg::PIX_W-1:0] pix_q  [3];
  logic                      last_q [3];
  logic [1:0]                wr_ptr, rd_ptr, count;
  logic                      pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = count != 2'd0;
  assign pixel_out  = pix_q[rd_ptr];
  assign frame_last = last_q[rd_ptr];
  // one result may still come out of the window stage
  assign space      = ({1'b0, count} + {2'b0, pending}) < DEPTH;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == 2'd2) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == 2'd2) ? 2'd0 : rd_ptr + 2'd1;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pix_q[wr_ptr]  <= push_pixel;
      last_q[wr_ptr] <= push_last;
    end
  end

endmodule

/* tb/sv/tb_emboss_filter_3x3_unit.sv */
// ----------------------------------------------------------------------------
// tb_emboss_filter_3x3_unit
// Streams raster frames of many sizes through the emboss filter with random
// gaps and output stalls. A scoreboard class keeps its own line stores and
// 3x3 window, predicts every filtered pixel and frame-last flag, and checks
// each output transfer in order against that prediction.
// ----------------------------------------------------------------------------
module tb_emboss_filter_3x3_unit;

  localparam int LINE_LEN     = 1024;
  localparam int HEIGHT_MAX   = 4096;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_WAIT   = 8;
  localparam int HOLD_CYCLES  = 48;
  localparam int ITEM_TARGET  = 850;

  // bottom-right corner heavy: center sum saturates high
  localparam logic [ef3_pkg::PIX_W-1:0] SAT_PATTERN [9] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255
  };

  class emboss_scoreboard;
    typedef struct {
      logic [ef3_pkg::PIX_W-1:0] pix;
      logic                      last;
    } filtered_px_t;

    filtered_px_t                 expected_px[$];
    logic [ef3_pkg::PIX_W-1:0]    upper_row [LINE_LEN];
    logic [ef3_pkg::PIX_W-1:0]    middle_row [LINE_LEN];
    logic [ef3_pkg::PIX_W-1:0]    win [9];
    int unsigned                  in_col;
    int unsigned                  in_row;
    int unsigned                  out_idx;
    logic [ef3_pkg::WIDTH_W-1:0]  width_reg;
    logic [ef3_pkg::HEIGHT_W-1:0] height_reg;
    int                           mismatches;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      width_reg  = 11'd256;
      height_reg = 13'd256;
      in_col     = 0;
      in_row     = 0;
      out_idx    = 0;
      mismatches = 0;
    endfunction

    function int unsigned row_len();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_LEN) return LINE_LEN;
      return int'(width_reg);
    endfunction

    function int unsigned frame_rows();
      if (height_reg == 0) return 1;
      if (height_reg > HEIGHT_MAX) return HEIGHT_MAX;
      return int'(height_reg);
    endfunction

    function int unsigned frame_pixels();
      return row_len() * frame_rows();
    endfunction

    function bit at_frame_start();
      return in_col == 0 && in_row == 0 && out_idx == 0;
    endfunction

    function void write_reg(logic idx, logic [ef3_pkg::CFG_W-1:0] data);
      if (idx == ef3_pkg::REG_IMAGE_WIDTH) width_reg = data[ef3_pkg::WIDTH_W-1:0];
      else height_reg = data[ef3_pkg::HEIGHT_W-1:0];
      in_col  = 0;
      in_row  = 0;
      out_idx = 0;
    endfunction

    function logic [ef3_pkg::PIX_W-1:0] emboss_sum();
      int s;
      s = int'(win[4]) + int'(win[5]) + int'(win[7]) + 2 * int'(win[8])
        - 2 * int'(win[0]) - int'(win[1]) - int'(win[3]);
      if (s < 0) s = 0;
      if (s > 255) s = 255;
      return s[ef3_pkg::PIX_W-1:0];
    endfunction

    function void push_pixel(int unsigned w, int unsigned h);
      filtered_px_t r;
      int unsigned  orow;
      int unsigned  ocol;
      orow = out_idx / w;
      ocol = out_idx % w;
      if (orow >= 1 && orow + 1 < h && ocol >= 1 && ocol + 1 < w) r.pix = emboss_sum();
      else r.pix = '0;
      r.last = (out_idx + 1 >= w * h);
      expected_px.push_back(r);
      if (r.last) begin
        in_row  = 0;
        in_col  = 0;
        out_idx = 0;
      end else begin
        out_idx++;
      end
    endfunction

    // returns 1 when the item moved the frame along or produced a pixel
    function bit note_input(logic o, logic [ef3_pkg::PIX_W-1:0] px);
      int unsigned w;
      int unsigned h;
      bit          complete;
      w        = row_len();
      h        = frame_rows();
      complete = in_row >= h;
      if (o == ef3_pkg::OP_PIXEL && !complete) begin
        win[0] = win[1]; win[1] = win[2];
        win[3] = win[4]; win[4] = win[5];
        win[6] = win[7]; win[7] = win[8];
        win[2] = upper_row[in_col];
        win[5] = middle_row[in_col];
        win[8] = px;
        upper_row[in_col]  = middle_row[in_col];
        middle_row[in_col] = px;
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
        end
        if (in_row * w + in_col >= out_idx + w + 2) push_pixel(w, h);
        return 1;
      end
      if (complete && out_idx < w * h) begin
        push_pixel(w, h);
        return 1;
      end
      return 0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(logic [ef3_pkg::PIX_W-1:0] pix, logic last);
      filtered_px_t r;
      if (expected_px.size() == 0) begin
        report($sformatf("unexpected output pixel_out=%0d frame_last=%0b", pix, last));
        return;
      end
      r = expected_px.pop_front();
      if (pix !== r.pix || last !== r.last)
        report($sformatf("pixel_out=%0d frame_last=%0b, expected pixel_out=%0d frame_last=%0b",
                         pix, last, r.pix, r.last));
    endfunction
  endclass

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        cfg_write = 1'b0;
  logic                        cfg_index = ef3_pkg::REG_IMAGE_WIDTH;
  logic [ef3_pkg::CFG_W-1:0]   cfg_data  = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic                        op        = ef3_pkg::OP_PIXEL;
  logic [ef3_pkg::PIX_W-1:0]   pixel_in  = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [ef3_pkg::PIX_W-1:0]   pixel_out;
  logic                        frame_last;

  emboss_scoreboard   emboss_sb;
  int                 effective_items = 0;
  int                 idle_cycles     = 0;
  bit                 in_idle_on      = 1'b1;
  bit                 out_idle_on     = 1'b1;
  bit                 hold_output     = 1'b0;

  emboss_filter_3x3_unit #(.MAX_WIDTH(LINE_LEN)) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .pixel_in   (pixel_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) emboss_sb.check_result(pixel_out, frame_last);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("** emboss_filter_3x3_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output side: random stall before each transfer, one long hold on request
  initial begin
    int stall;
    forever begin
      if (hold_output) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        stall = out_idle_on ? $urandom_range(0, 4) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic logic [ef3_pkg::PIX_W-1:0] rand_pixel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ef3_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  task automatic send_item(logic o, logic [ef3_pkg::PIX_W-1:0] px);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    pixel_in <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (emboss_sb.note_input(o, px)) effective_items++;
  endtask

  // hold the input until every predicted pixel is out, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (emboss_sb.expected_px.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_frame(logic [ef3_pkg::CFG_W-1:0] w_data,
                           logic [ef3_pkg::CFG_W-1:0] h_data);
    cfg_write <= 1'b1;
    cfg_index <= ef3_pkg::REG_IMAGE_WIDTH;
    cfg_data  <= w_data;
    @(posedge clk);
    emboss_sb.write_reg(ef3_pkg::REG_IMAGE_WIDTH, w_data);
    cfg_index <= ef3_pkg::REG_IMAGE_HEIGHT;
    cfg_data  <= h_data;
    @(posedge clk);
    emboss_sb.write_reg(ef3_pkg::REG_IMAGE_HEIGHT, h_data);
    cfg_write <= 1'b0;
  endtask

  task automatic run_frame(logic [ef3_pkg::CFG_W-1:0] w_data,
                           logic [ef3_pkg::CFG_W-1:0] h_data,
                           bit cut_short);
    int unsigned n;
    int unsigned i;
    wait_idle();
    set_frame(w_data, h_data);
    n = emboss_sb.frame_pixels();
    if (cut_short) n = $urandom_range(0, n - 1);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(ef3_pkg::OP_FLUSH, rand_pixel());
      send_item(ef3_pkg::OP_PIXEL, rand_pixel());
    end
    // drain: a pixel after the frame is complete counts as a flush
    if (!cut_short) begin
      while (!emboss_sb.at_frame_start())
        send_item(($urandom_range(0, 3) == 0) ? ef3_pkg::OP_PIXEL : ef3_pkg::OP_FLUSH,
                  rand_pixel());
      if ($urandom_range(0, 3) == 0) send_item(ef3_pkg::OP_FLUSH, rand_pixel());
    end
  endtask

  initial begin
    int unsigned r;
    int unsigned w_pick;
    int unsigned h_pick;
    int          i;
    emboss_sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // nothing pending, then a flush in the middle of a default-size frame
    send_item(ef3_pkg::OP_FLUSH, 8'hA5);
    send_item(ef3_pkg::OP_PIXEL, 8'hFF);
    send_item(ef3_pkg::OP_PIXEL, 8'h00);
    send_item(ef3_pkg::OP_PIXEL, 8'hFF);
    send_item(ef3_pkg::OP_FLUSH, 8'h5A);

    // zero sizes clamp to a single border pixel; restarts the partial frame
    wait_idle();
    set_frame(13'd0, 13'd0);
    send_item(ef3_pkg::OP_PIXEL, 8'hFF);
    send_item(ef3_pkg::OP_PIXEL, 8'h5A);

    wait_idle();
    set_frame(13'd3, 13'd3);
    for (i = 0; i < 9; i++) send_item(ef3_pkg::OP_PIXEL, SAT_PATTERN[i]);
    send_item(ef3_pkg::OP_FLUSH, 8'h00);
    send_item(ef3_pkg::OP_PIXEL, 8'hFF);
    send_item(ef3_pkg::OP_FLUSH, 8'hFF);
    send_item(ef3_pkg::OP_FLUSH, 8'h00);

    // all register bits set clamp to the widest and tallest frame; the
    // partial frame is cut off by the next register write
    wait_idle();
    set_frame(13'h1FFF, 13'h1FFF);
    for (i = 0; i < 20; i++) send_item(ef3_pkg::OP_PIXEL, rand_pixel());
    send_item(ef3_pkg::OP_FLUSH, 8'h00);

    // stall the output long enough to back up the input
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    hold_output = 1'b1;
    run_frame(13'd24, 13'd5, 1'b0);

    while (effective_items < ITEM_TARGET) begin
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 9);
      if (r < 7) w_pick = $urandom_range(1, 12);
      else if (r < 9) w_pick = $urandom_range(13, 40);
      else w_pick = $urandom_range(0, 2);
      h_pick = $urandom_range(0, 8);
      run_frame(ef3_pkg::CFG_W'(w_pick), ef3_pkg::CFG_W'(h_pick), $urandom_range(0, 9) == 0);
    end

    wait_idle();
    if (emboss_sb.mismatches == 0 && emboss_sb.expected_px.size() == 0) begin
      $display("** emboss_filter_3x3_unit: PASSED **");
    end else begin
      $display("** emboss_filter_3x3_unit: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ef3_pkg.sv
rtl/ef3_line_mem.sv
rtl/ef3_ctrl.sv
rtl/ef3_window.sv
rtl/ef3_out_fifo.sv
rtl/emboss_filter_3x3_unit.sv
tb/sv/tb_emboss_filter_3x3_unit.sv
